### src/sobel_edge_magnitude_rgb_defines.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored during reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers reset
`define SEM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared sizes, register indexes, payload words and control types.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int SIZE_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 24;
  localparam int SUM_W      = 21;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       flush;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } edge_out_t;

  typedef logic [2:0][2:0][PIX_W-1:0] rgb_taps_t;
  typedef logic [2:0][2:0][7:0]       chan_taps_t;

  typedef struct packed {
    logic       grad;
    logic       square;
    logic       root_step;
    logic [2:0] root_bit;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_GRAD,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } sem_state_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

### src/sem_window.sv
// ----------------------------------------------------------------------------
// Sobel window and row stores
// Tracks the frame position, keeps two previous rows and the 3x3 window,
// and registers the masked neighborhood of the pixel being finished.
// ----------------------------------------------------------------------------
module sem_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  sem_pkg::pixel_in_t        in_data,
  input  logic                      step,
  input  logic                      restart,
  input  logic [sem_pkg::SIZE_W-1:0] frame_width,
  input  logic [sem_pkg::SIZE_W-1:0] frame_height,
  output logic                      emit,
  output sem_pkg::rgb_taps_t        taps,
  output logic                      frame_end
);
  import sem_pkg::*;

  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] lower_rd;
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  rgb_taps_t        win;
  rgb_taps_t        win_next;
  rgb_taps_t        taps_next;
  logic             case_a;
  logic             case_b;
  logic             end_hit;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [ROW_W:0]   rw;
  logic [ROW_W:0]   hw;
  logic [ROW_W:0]   cw;
  logic [ROW_W:0]   ww;
  logic [COL_W:0]   col_inc;

  // Which delayed pixel finishes now, and which neighbors are inside the frame
  always_comb begin
    rw = {1'b0, row_pos};
    hw = {1'b0, frame_height};
    cw = (ROW_W+1)'(col_pos);
    ww = {1'b0, frame_width};
    case_a = (col_pos != '0) && (row_pos != '0);
    case_b = (col_pos == '0) && (rw >= (ROW_W+1)'(2));
    emit   = case_a || case_b;
    row_ok[0] = case_a ? (rw >= (ROW_W+1)'(2)) : (rw >= (ROW_W+1)'(3));
    row_ok[1] = 1'b1;
    row_ok[2] = case_a ? (rw < hw) : (rw <= hw);
    col_ok[0] = case_a ? (cw >= (ROW_W+1)'(2)) : (ww >= (ROW_W+1)'(2));
    col_ok[1] = 1'b1;
    col_ok[2] = case_a ? (cw < ww) : 1'b0;
    end_hit   = case_a ? ((rw == hw) && (cw == ww)) : (rw == hw + (ROW_W+1)'(1));
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = upper_rd;
    win_next[1][2] = lower_rd;
    win_next[2][2] = pix;
    for (int k = 0; k < 3; k++) begin
      taps_next[k][0] = case_a ? win_next[k][0] : win[k][1];
      taps_next[k][1] = case_a ? win_next[k][1] : win[k][2];
      taps_next[k][2] = case_a ? win_next[k][2] : '0;
      for (int j = 0; j < 3; j++) begin
        if (!(row_ok[k] && col_ok[j])) taps_next[k][j] = '0;
      end
    end
    col_inc = {1'b0, col_pos} + (COL_W+1)'(1);
  end

  // Latch pixel, read row stores; on a step update them and register the taps
  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= (!in_data.flush && (row_pos < frame_height)) ?
             {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue} : '0;
      upper_rd <= upper_mem[col_pos];
      lower_rd <= lower_mem[col_pos];
    end
    if (step) begin
      upper_mem[col_pos] <= lower_rd;
      lower_mem[col_pos] <= pix;
      taps      <= taps_next;
      frame_end <= end_hit;
    end
  end

  // Shift the window and advance the position
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      col_pos <= '0;
      row_pos <= '0;
    end else if (restart) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (step) begin
      win <= win_next;
      if (emit && end_hit) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if ({1'b0, col_inc} >= {1'b0, frame_width}) begin
        col_pos <= '0;
        row_pos <= row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

### src/sem_lane.sv
// ----------------------------------------------------------------------------
// Sobel channel lane
// Gradients, squared magnitude and a bit-per-cycle rounded square root
// for one color channel.
// ----------------------------------------------------------------------------
module sem_lane (
  input  logic                clk,
  input  sem_pkg::chan_taps_t taps,
  input  sem_pkg::lane_ctl_t  ctl,
  output logic [7:0]          root
);
  import sem_pkg::*;

  logic signed [10:0] e [3][3];
  logic signed [10:0] gx;
  logic signed [10:0] gy;
  logic signed [10:0] gx_next;
  logic signed [10:0] gy_next;
  logic signed [21:0] sq_x;
  logic signed [21:0] sq_y;
  logic [SUM_W-1:0]   sum;
  logic [7:0]         trial;
  logic [15:0]        prod;

  // Apply the two kernels
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        e[k][j] = $signed({3'b000, taps[k][j]});
      end
    end
    gx_next = e[0][2] + e[1][2] + e[1][2] + e[2][2] - e[0][0] - e[1][0] - e[1][0] - e[2][0];
    gy_next = e[2][0] + e[2][1] + e[2][1] + e[2][2] - e[0][0] - e[0][1] - e[0][1] - e[0][2];
    sq_x  = gx * gx;
    sq_y  = gy * gy;
    trial = root | (8'd1 << ctl.root_bit);
    prod  = trial * (trial - 8'd1);
  end

  // Hold gradients, then the sum of squares, then refine the root
  always_ff @(posedge clk) begin
    if (ctl.grad) begin
      gx <= gx_next;
      gy <= gy_next;
    end
    if (ctl.square) begin
      sum  <= sq_x[SUM_W-1:0] + sq_y[SUM_W-1:0];
      root <= '0;
    end
    if (ctl.root_step && ({{(SUM_W-16){1'b0}}, prod} < sum)) begin
      root <= trial;
    end
  end

endmodule

### src/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Each accepted word is shifted into the window; when a result is due it goes
// on through gradients, squares and the 8-step square root that each channel
// lane runs. One word is in work at a time; a stalled output adds its wait.
// Reset: frame size 640x480, position and window cleared; row stores unset.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sem_pkg::pixel_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sem_pkg::edge_out_t           out_data,
  input  logic                         cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::SIZE_W-1:0]   cfg_data
);
  import sem_pkg::*;

  sem_state_t        state;
  sem_state_t        state_next;
  logic [2:0]        root_bit;
  logic [2:0]        root_bit_next;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              restart;
  logic              accept;
  logic              step;
  logic              emit;
  logic              frame_end;
  logic              load_out;
  rgb_taps_t         taps;
  lane_ctl_t         ctl;
  logic [2:0][7:0]   roots;

  assign accept  = in_valid && in_ready;
  assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                              (cfg_index == REG_FRAME_HEIGHT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= clamp_size(cfg_data, WIDTH_MAX);
        REG_FRAME_HEIGHT: frame_height <= clamp_size(cfg_data, HEIGHT_MAX);
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      root_bit <= 3'd7;
    end else begin
      state    <= state_next;
      root_bit <= root_bit_next;
    end
  end

  // Walk one word through window, gradients, squares and root
  always_comb begin
    state_next    = state;
    root_bit_next = root_bit;
    in_ready      = 1'b0;
    step          = 1'b0;
    load_out      = 1'b0;
    ctl           = '0;
    ctl.root_bit  = root_bit;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_WIN;
      end
      ST_WIN: begin
        step       = 1'b1;
        state_next = emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        ctl.grad   = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        ctl.square    = 1'b1;
        root_bit_next = 3'd7;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        ctl.root_step = 1'b1;
        root_bit_next = root_bit - 3'd1;
        if (root_bit == 3'd0) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  sem_window u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .step         (step),
    .restart      (restart),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .emit         (emit),
    .taps         (taps),
    .frame_end    (frame_end)
  );

  // One lane per color channel
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    chan_taps_t lane_taps;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          lane_taps[k][j] = taps[k][j][PIX_W-1-8*ch -: 8];
        end
      end
    end
    sem_lane u_lane (
      .clk  (clk),
      .taps (lane_taps),
      .ctl  (ctl),
      .root (roots[ch])
    );
  end

  // Merge the lanes into the output word and hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_data.edge_red   <= roots[0];
      out_data.edge_green <= roots[1];
      out_data.edge_blue  <= roots[2];
      out_data.frame_end  <= frame_end;
    end
  end

endmodule

### src/sem_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude port checker
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_rgb_defines.svh"

module sem_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input sem_pkg::edge_out_t            out_data
);
  import sem_pkg::*;

  // Stalled output word holds
  `SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data), "output word changed while stalled")
  // One word in work at a time
  `SEM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "input taken while a word is in work")
  // A new result only comes out of work in progress
  `SEM_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready),
                  "result word without work")
  // Reset leaves the block empty and ready
  `SEM_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid && in_ready,
                     "block not empty after reset")

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
